// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, suspended while reset is applied.
`define HSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HSFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/hsfr_pkg.sv =====
// Package of shared types and constants for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package hsfr_pkg;

  localparam int unsigned FRAME_LEN_DEF = 8;

  typedef struct packed {
    logic wr_en;
    logic load_en;
  } hsfr_cmd_t;

  typedef struct packed {
    logic last_pos;
    logic last_rd;
  } hsfr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hsfr_if.sv =====
// Stream interfaces for the input words and the result words of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

interface hsfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface hsfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       crc_match;

  modport source (output valid, output frame_byte, output last_byte, output crc_match,
                  input ready);
  modport sink (input valid, input frame_byte, input last_byte, input crc_match,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/hsfr_ctrl.sv =====
// Controller state machine of the frame receiver: reception, hold and frame drain.
`timescale 1ns / 1ps
`default_nettype none

module hsfr_ctrl
  import hsfr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_op_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire hsfr_sts_t sts_i,
  output hsfr_cmd_t      cmd_o
);

  typedef enum logic {
    ST_RECV,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   held_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o    = (state_q == ST_RECV);
  assign accept        = in_valid_i && in_ready_o;
  assign cmd_o.wr_en   = accept && !in_op_i && !held_q;
  assign cmd_o.load_en = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RECV;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_RECV: begin
          if (accept && in_op_i) begin
            held_q <= 1'b0;
          end
          if (cmd_o.wr_en && sts_i.last_pos) begin
            held_q  <= 1'b1;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cmd_o.load_en && sts_i.last_rd) begin
            state_q <= ST_RECV;
          end
        end
        default: begin
          state_q <= ST_RECV;
        end
      endcase
      if (cmd_o.load_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsfr_datapath.sv =====
// Datapath of the frame receiver: frame store, position counter, CRC and output register.
`timescale 1ns / 1ps
`default_nettype none

module hsfr_datapath
  import hsfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hsfr_cmd_t  cmd_i,
  output hsfr_sts_t       sts_o,
  input  wire logic [7:0] rx_byte_i,
  output logic [7:0]      frame_byte_o,
  output logic            last_byte_o,
  output logic            crc_match_o
);

  localparam int unsigned PW        = $clog2(FRAME_LEN);
  localparam logic [7:0]  SYNC0     = 8'hFF;
  localparam logic [7:0]  SYNC1     = 8'hCC;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [PW-1:0] POS_ONE  = PW'(1);
  localparam logic [PW-1:0] POS_LAST = PW'(FRAME_LEN - 1);
  localparam logic [PW-1:0] POS_HI   = PW'(FRAME_LEN - 2);

  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [7:0]    store_q [FRAME_LEN];
  logic [PW-1:0] pos_q;
  logic [PW-1:0] rd_idx_q;
  logic [15:0]   crc_q;
  logic [7:0]    crc_hi_q;
  logic          match_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;
  logic          out_match_q;

  assign sts_o.last_pos = (pos_q == POS_LAST);
  assign sts_o.last_rd  = (rd_idx_q == POS_LAST);
  assign frame_byte_o   = out_byte_q;
  assign last_byte_o    = out_last_q;
  assign crc_match_o    = out_match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rd_idx_q <= '0;
      crc_q    <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        if (pos_q == '0) begin
          crc_q <= '0;
          pos_q <= (rx_byte_i == SYNC0) ? POS_ONE : '0;
        end else if (pos_q == POS_ONE) begin
          pos_q <= (rx_byte_i == SYNC1) ? PW'(2) : '0;
        end else begin
          if (pos_q < POS_HI) begin
            crc_q <= crc_add(crc_q, rx_byte_i);
          end
          if (pos_q == POS_LAST) begin
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + POS_ONE;
          end
        end
      end
      if (cmd_i.load_en) begin
        rd_idx_q <= sts_o.last_rd ? '0 : rd_idx_q + POS_ONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[pos_q] <= rx_byte_i;
      if (pos_q == POS_HI) begin
        crc_hi_q <= rx_byte_i;
      end
      if (pos_q == POS_LAST) begin
        match_q <= ({crc_hi_q, rx_byte_i} == crc_q);
      end
    end
    if (cmd_i.load_en) begin
      out_byte_q  <= store_q[rd_idx_q];
      out_last_q  <= sts_o.last_rd;
      out_match_q <= sts_o.last_rd && match_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/header_sync_frame_receiver_crc_unit.sv =====
// Top level of the sync-header frame receiver with CRC-16/XMODEM check.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Receives bytes into frames of FRAME_LEN bytes that open with 0xFF, 0xCC and close with
// a big-endian CRC-16/XMODEM over the bytes between. Each input word is a byte or a release.
// The word carrying the final byte of a frame starts a drain of the frame store through
// the output register, one stored byte per cycle while the consumer does not stall the
// output. Input is not ready during the drain. After the drain the frame stays held:
// bytes are accepted and dropped until a release word arrives.

module header_sync_frame_receiver_crc_unit
  import hsfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hsfr_in_if.sink     in_i,
  hsfr_out_if.source  out_o
);

  hsfr_cmd_t cmd;
  hsfr_sts_t sts;
  logic      in_ready;

  assign in_i.ready = in_ready;

  hsfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hsfr_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rx_byte_i    (in_i.rx_byte),
    .frame_byte_o (out_o.frame_byte),
    .last_byte_o  (out_o.last_byte),
    .crc_match_o  (out_o.crc_match)
  );

  `HSFR_ASSERT(a_wr_needs_accept, cmd.wr_en |-> (in_i.valid && in_ready), "store write without accepted word")
  `HSFR_ASSERT(a_no_wr_during_load, cmd.wr_en |-> !cmd.load_en, "store written while draining")
  `HSFR_ASSERT(a_match_on_last, (out_o.valid && out_o.crc_match) |-> out_o.last_byte, "CRC flag off the last word")
  `HSFR_ASSERT_ALWAYS(a_no_load_in_recv, !(cmd.load_en && in_ready), "drain load while input ready")

endmodule

`default_nettype wire

// ===== test/hsfr_tb_pkg.sv =====
// Shared word codes, result type and CRC-16/XMODEM step for the frame receiver testbench.
`timescale 1ns / 1ps

package hsfr_tb_pkg;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } hsfr_op_e;

  localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND = 8'hCC;
  localparam logic [15:0] CRC16_POLY  = 16'h1021;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       crc_match;
  } frame_word_t;

  function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
                                                    input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      acc = acc[15] ? ((acc << 1) ^ CRC16_POLY) : (acc << 1);
    end
    return acc;
  endfunction

endpackage

// ===== test/hsfr_frame_checker.sv =====
// Checker that predicts the emitted frame words from the accepted input words and compares.
`timescale 1ns / 1ps

module hsfr_frame_checker
  import hsfr_pkg::*;
  import hsfr_tb_pkg::*;
#(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsfr_in_if          in_mon,
  hsfr_out_if         out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  logic [7:0]  frame_buf [FRAME_LEN];
  int unsigned rx_pos;
  logic [15:0] crc_acc;
  logic        held;
  frame_word_t frame_words_due [$];
  int unsigned mismatches = 0;
  int unsigned waiting_words;

  assign fail_cnt_o = mismatches;
  assign pending_o  = waiting_words;

  task automatic track_rx_word(input hsfr_op_e op, input logic [7:0] data);
    logic [15:0] trailing;
    frame_word_t w;
    if (op == OP_RELEASE) begin
      held = 1'b0;
      return;
    end
    if (held) return;
    frame_buf[rx_pos] = data;
    if (rx_pos == 0) begin
      crc_acc = '0;
      rx_pos  = (data == SYNC_FIRST) ? 1 : 0;
    end else if (rx_pos == 1) begin
      rx_pos = (data == SYNC_SECOND) ? 2 : 0;
    end else begin
      if (rx_pos + 2 < FRAME_LEN) crc_acc = crc16_xmodem_step(crc_acc, data);
      if (rx_pos + 1 < FRAME_LEN) begin
        rx_pos++;
      end else begin
        trailing = {frame_buf[FRAME_LEN-2], frame_buf[FRAME_LEN-1]};
        for (int k = 0; k < FRAME_LEN; k++) begin
          w.frame_byte = frame_buf[k];
          w.last_byte  = (k == FRAME_LEN - 1);
          w.crc_match  = (k == FRAME_LEN - 1) && (trailing == crc_acc);
          frame_words_due.push_back(w);
        end
        rx_pos  = 0;
        crc_acc = '0;
        held    = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < FRAME_LEN; k++) frame_buf[k] = '0;
      rx_pos  = 0;
      crc_acc = '0;
      held    = 1'b0;
      frame_words_due.delete();
      waiting_words <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (frame_words_due.size() == 0) begin
          $error("Unexpected frame word: frame_byte %02h, last_byte %0b, crc_match %0b",
                 out_mon.frame_byte, out_mon.last_byte, out_mon.crc_match);
          mismatches++;
        end else begin
          want = frame_words_due.pop_front();
          if (out_mon.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %02h, actual %02h", want.frame_byte,
                   out_mon.frame_byte);
            mismatches++;
          end
          if (out_mon.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, out_mon.last_byte);
            mismatches++;
          end
          if (out_mon.crc_match !== want.crc_match) begin
            $error("crc_match: expected %0b, actual %0b", want.crc_match, out_mon.crc_match);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        track_rx_word(hsfr_op_e'(in_mon.op), in_mon.rx_byte);
      end
      waiting_words <= frame_words_due.size();
    end
  end

endmodule

// ===== test/header_sync_frame_receiver_crc_unit_tb.sv =====
// Testbench top: drives bytes and releases into the frame receiver and gives the verdict.
`timescale 1ns / 1ps

module header_sync_frame_receiver_crc_unit_tb;
  import hsfr_pkg::*;
  import hsfr_tb_pkg::*;

  localparam int unsigned FRAME_LEN       = FRAME_LEN_DEF;
  localparam int unsigned RANDOM_WORDS    = 480;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HOLD_AFTER      = 150;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt = 0;

  hsfr_in_if  in_if ();
  hsfr_out_if out_if ();

  header_sync_frame_receiver_crc_unit #(.FRAME_LEN(FRAME_LEN)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hsfr_frame_checker #(.FRAME_LEN(FRAME_LEN)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver stalls in stretches of varying density, with one long hold-off once
  // traffic is flowing so that the block fills up and stalls its input.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned hold_left;
    bit          hold_done;
    mode      = 0;
    stretch   = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_sent >= HOLD_AFTER && out_if.valid) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(10, 60);
        end
        stretch--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input hsfr_op_e op, input logic [7:0] data, input bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.rx_byte <= data;
    do @(posedge clk_i); while (!in_if.ready);
    if (counted) words_sent++;
  endtask

  task automatic send_frame(input logic [7:0] body[$], input bit crc_ok);
    logic [15:0] crc;
    crc = '0;
    foreach (body[i]) crc = crc16_xmodem_step(crc, body[i]);
    if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    send_word(OP_BYTE, SYNC_FIRST, 1'b1);
    send_word(OP_BYTE, SYNC_SECOND, 1'b1);
    foreach (body[i]) send_word(OP_BYTE, body[i], 1'b1);
    send_word(OP_BYTE, crc[15:8], 1'b1);
    send_word(OP_BYTE, crc[7:0], 1'b1);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return SYNC_FIRST;
      1: return SYNC_SECOND;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0]  body[$];
    logic [7:0]  edge_vals[4];
    int unsigned target;
    int unsigned kind;
    edge_vals = '{8'h00, 8'hFF, 8'h80, 8'h01};
    in_if.valid   <= 1'b0;
    in_if.op      <= OP_BYTE;
    in_if.rx_byte <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: header mismatches, a held frame, release handling and both CRC outcomes.
    send_word(OP_RELEASE, 8'($urandom), 1'b1);
    send_word(OP_BYTE, 8'h00, 1'b1);
    send_word(OP_BYTE, SYNC_FIRST, 1'b1);
    send_word(OP_BYTE, 8'h00, 1'b1);
    send_word(OP_BYTE, SYNC_FIRST, 1'b1);
    send_word(OP_BYTE, SYNC_FIRST, 1'b1);
    body.delete();
    for (int i = 0; i < FRAME_LEN - 4; i++) body.push_back(edge_vals[i % 4]);
    send_frame(body, 1'b1);
    send_word(OP_BYTE, 8'hA5, 1'b0);
    send_word(OP_RELEASE, 8'($urandom), 1'b1);
    body.delete();
    for (int i = 0; i < FRAME_LEN - 4; i++) body.push_back(8'($urandom));
    send_frame(body, 1'b0);
    send_word(OP_RELEASE, 8'($urandom), 1'b1);

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        body.delete();
        for (int i = 0; i < FRAME_LEN - 4; i++) body.push_back(8'($urandom));
        send_frame(body, $urandom_range(0, 4) != 0);
        repeat ($urandom_range(0, 2)) send_word(OP_BYTE, 8'($urandom), 1'b0);
        send_word(OP_RELEASE, 8'($urandom), 1'b1);
      end else if (kind < 17) begin
        // A broken or cut-short frame followed by a release.
        send_word(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYNC_FIRST, 1'b1);
        send_word(OP_BYTE, pick_byte(), 1'b1);
        repeat ($urandom_range(0, FRAME_LEN - 1)) send_word(OP_BYTE, pick_byte(), 1'b1);
        send_word(OP_RELEASE, 8'($urandom), 1'b1);
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(hsfr_op_e'($urandom_range(0, 1)), pick_byte(), 1'b1);
        end
      end else begin
        send_word(OP_RELEASE, 8'($urandom), 1'b1);
      end
    end
    in_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (4 * FRAME_LEN) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
